@@ rtl/core/gpb_pkg.sv @@
package gpb_pkg;

  localparam int unsigned GPB_SCREEN_W = 320;
  localparam int unsigned GPB_SCREEN_H = 200;

  localparam int unsigned COORD_W     = 11;
  localparam int unsigned PIX_COORD_W = COORD_W + 1;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned GIDX_W      = 6;
  localparam int unsigned ROW_IDX_W   = 3;
  localparam int unsigned COL_IDX_W   = 3;

  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned GLYPH_COLS  = 8;
  localparam int unsigned GLYPH_COUNT = 47;

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(GLYPH_ROWS - 1);
  localparam logic [COL_IDX_W-1:0] LAST_COL = COL_IDX_W'(GLYPH_COLS - 1);

  localparam logic [GIDX_W-1:0] GLYPH_COLON = 6'd10;
  localparam logic [GIDX_W-1:0] GLYPH_BLOCK = 6'd46;

  localparam logic [7:0] GLYPH_ROM [0:GLYPH_COUNT-1][0:GLYPH_ROWS-1] = '{
    '{8'h70, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70},
    '{8'h20, 8'h60, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
    '{8'h70, 8'h88, 8'h08, 8'h10, 8'h20, 8'h40, 8'hF8},
    '{8'h70, 8'h88, 8'h08, 8'h30, 8'h08, 8'h88, 8'h70},
    '{8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10},
    '{8'hF8, 8'h80, 8'hF0, 8'h08, 8'h08, 8'h88, 8'h70},
    '{8'h30, 8'h40, 8'h80, 8'hF0, 8'h88, 8'h88, 8'h70},
    '{8'hF8, 8'h08, 8'h10, 8'h20, 8'h40, 8'h40, 8'h40},
    '{8'h70, 8'h88, 8'h88, 8'h70, 8'h88, 8'h88, 8'h70},
    '{8'h70, 8'h88, 8'h88, 8'h78, 8'h08, 8'h10, 8'h60},
    '{8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00},
    '{8'h20, 8'h50, 8'h88, 8'h88, 8'hF8, 8'h88, 8'h88},
    '{8'hF8, 8'h80, 8'h80, 8'hF0, 8'h80, 8'h80, 8'hF8},
    '{8'hF8, 8'h80, 8'h80, 8'hF0, 8'h80, 8'h80, 8'h80},
    '{8'h70, 8'h88, 8'h80, 8'hB8, 8'h88, 8'h88, 8'h70},
    '{8'h70, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
    '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hF8},
    '{8'h88, 8'hD8, 8'hA8, 8'hA8, 8'h88, 8'h88, 8'h88},
    '{8'h88, 8'h88, 8'hC8, 8'hA8, 8'h98, 8'h88, 8'h88},
    '{8'h70, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70},
    '{8'hF0, 8'h88, 8'h88, 8'hF0, 8'h80, 8'h80, 8'h80},
    '{8'hF0, 8'h88, 8'h88, 8'hF0, 8'h90, 8'h88, 8'h88},
    '{8'h70, 8'h88, 8'h80, 8'h70, 8'h08, 8'h88, 8'h70},
    '{8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70},
    '{8'h88, 8'h88, 8'h88, 8'h88, 8'h50, 8'h50, 8'h20},
    '{8'h88, 8'h88, 8'h88, 8'hA8, 8'hA8, 8'hD8, 8'h88},
    '{8'h88, 8'h88, 8'h50, 8'h20, 8'h20, 8'h20, 8'h20},
    '{8'h00, 8'h00, 8'h70, 8'h08, 8'h78, 8'h88, 8'h78},
    '{8'h00, 8'h00, 8'h70, 8'h80, 8'h80, 8'h88, 8'h70},
    '{8'h00, 8'h00, 8'h70, 8'h88, 8'hF8, 8'h80, 8'h70},
    '{8'h20, 8'h00, 8'h60, 8'h20, 8'h20, 8'h20, 8'h70},
    '{8'h80, 8'h80, 8'h90, 8'hA0, 8'hE0, 8'h90, 8'h88},
    '{8'h60, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
    '{8'h00, 8'h00, 8'hB0, 8'hC8, 8'h88, 8'h88, 8'h88},
    '{8'h00, 8'h00, 8'h70, 8'h88, 8'h88, 8'h88, 8'h70},
    '{8'h00, 8'h00, 8'h68, 8'h70, 8'h40, 8'h40, 8'h40},
    '{8'h00, 8'h00, 8'h70, 8'h80, 8'h70, 8'h08, 8'hF0},
    '{8'h20, 8'h20, 8'h70, 8'h20, 8'h20, 8'h20, 8'h18},
    '{8'h00, 8'h00, 8'h88, 8'h88, 8'h88, 8'h50, 8'h20},
    '{8'h00, 8'h00, 8'h88, 8'h50, 8'h20, 8'h50, 8'h88},
    '{8'h00, 8'h00, 8'h88, 8'h88, 8'h78, 8'h08, 8'h70},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h88, 8'h80, 8'h80, 8'h80, 8'h88, 8'h70},
    '{8'hF0, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'hF0},
    '{8'h88, 8'h98, 8'hA8, 8'hC0, 8'hA8, 8'h98, 8'h88},
    '{8'hF8, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hF8},
    '{8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8, 8'hF8}
  };

  typedef struct packed {
    logic                        valid;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic [GIDX_W-1:0]           gidx;
    logic [COLOR_W-1:0]          ink;
    logic                        transp;
    logic [ROW_IDX_W-1:0]        row;
    logic [COL_IDX_W-1:0]        col;
  } gpb_slot_t;

  function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [GIDX_W-1:0] idx;
    idx = GLYPH_BLOCK;
    if (code inside {["0":"9"]}) begin
      idx = GIDX_W'(code - "0");
    end else begin
      case (code)
        ":": idx = GLYPH_COLON;
        "A": idx = 6'd11;
        "C": idx = 6'd42;
        "D": idx = 6'd43;
        "E": idx = 6'd12;
        "F": idx = 6'd13;
        "G": idx = 6'd14;
        "I": idx = 6'd15;
        "K": idx = 6'd44;
        "L": idx = 6'd16;
        "M": idx = 6'd17;
        "N": idx = 6'd18;
        "O": idx = 6'd19;
        "P": idx = 6'd20;
        "R": idx = 6'd21;
        "S": idx = 6'd22;
        "U": idx = 6'd23;
        "V": idx = 6'd24;
        "W": idx = 6'd25;
        "Y": idx = 6'd26;
        "Z": idx = 6'd45;
        "a": idx = 6'd27;
        "c": idx = 6'd28;
        "e": idx = 6'd29;
        "i": idx = 6'd30;
        "k": idx = 6'd31;
        "l": idx = 6'd32;
        "n": idx = 6'd33;
        "o": idx = 6'd34;
        "r": idx = 6'd35;
        "s": idx = 6'd36;
        "t": idx = 6'd37;
        "v": idx = 6'd38;
        "x": idx = 6'd39;
        "y": idx = 6'd40;
        " ": idx = 6'd41;
        default: idx = GLYPH_BLOCK;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [7:0] glyph_row(input logic [GIDX_W-1:0] gidx,
                                           input logic [ROW_IDX_W-1:0] row);
    logic [7:0] bits;
    bits = 8'h00;
    if (gidx < GIDX_W'(GLYPH_COUNT) && row < ROW_IDX_W'(GLYPH_ROWS)) begin
      bits = GLYPH_ROM[gidx][row];
    end
    return bits;
  endfunction

endpackage

@@ rtl/core/gpb_cmd_seq.sv @@
module gpb_cmd_seq
  import gpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_x_pos,
  input  logic signed [COORD_W-1:0] in_y_pos,
  input  logic [CODE_W-1:0]         in_char_code,
  input  logic [COLOR_W-1:0]        in_ink_color,
  input  logic                      in_transparent,
  input  logic                      adv,
  output gpb_slot_t                 slot
);

  logic                      busy_r, busy_nxt;
  logic [ROW_IDX_W-1:0]      row_r, row_nxt;
  logic [COL_IDX_W-1:0]      col_r, col_nxt;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [GIDX_W-1:0]         gidx_r;
  logic [COLOR_W-1:0]        ink_r;
  logic                      transp_r;
  logic                      last_pix;
  logic                      accept;

  assign last_pix = (row_r == LAST_ROW) && (col_r == LAST_COL);
  assign in_stall = busy_r && !(adv && last_pix);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (accept) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
    end else if (busy_r && adv) begin
      if (last_pix) begin
        busy_nxt = 1'b0;
      end else if (col_r == LAST_COL) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_x_pos;
      y_r      <= in_y_pos;
      gidx_r   <= glyph_index(in_char_code);
      ink_r    <= in_ink_color;
      transp_r <= in_transparent;
    end
  end

  always_comb begin
    slot.valid  = busy_r;
    slot.x      = x_r;
    slot.y      = y_r;
    slot.gidx   = gidx_r;
    slot.ink    = ink_r;
    slot.transp = transp_r;
    slot.row    = row_r;
    slot.col    = col_r;
  end

endmodule

@@ rtl/core/glyph_pixel_blitter_unit.sv @@
// Character generator for an 8x7 bitmap font. Each accepted command draws one glyph cell
// and yields 56 pixel beats, rows top to bottom, left to right, the last one flagged by
// out_last. The command sequencer issues one pixel per cycle unless the output stalls;
// the next command is taken in the cycle that issues the last pixel of the current one,
// so pixels stream without gaps. A pixel passes through registered stages for glyph
// fetch, bounds and row multiply, and address add before it reaches the output.
// Off-screen pixels come out with write enable, address and color all zero. cfg_data
// sets the opaque background color; cfg_ready is always high.
module glyph_pixel_blitter_unit
  import gpb_pkg::*;
#(
  parameter int unsigned SCREEN_W = GPB_SCREEN_W,
  parameter int unsigned SCREEN_H = GPB_SCREEN_H
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_x_pos,
  input  logic signed [COORD_W-1:0] in_y_pos,
  input  logic [CODE_W-1:0]         in_char_code,
  input  logic [COLOR_W-1:0]        in_ink_color,
  input  logic                      in_transparent,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ADDR_W-1:0]         out_pixel_addr,
  output logic [COLOR_W-1:0]        out_pixel_color,
  output logic                      out_write_enable,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COLOR_W-1:0]        cfg_data
);

  localparam logic [COORD_W-1:0] W_LIM = COORD_W'(SCREEN_W);
  localparam logic [COORD_W-1:0] H_LIM = COORD_W'(SCREEN_H);
  localparam logic [ADDR_W-1:0]  W_MUL = ADDR_W'(SCREEN_W);

  gpb_slot_t slot;
  logic      adv;

  logic [COLOR_W-1:0] bg_r;

  logic                   s1_valid_r;
  logic [PIX_COORD_W-1:0] s1_px_r, s1_py_r;
  logic                   s1_set_r;
  logic [COLOR_W-1:0]     s1_ink_r;
  logic                   s1_transp_r;
  logic                   s1_last_r;
  logic [7:0]             row_bits;

  logic                   s2_valid_r;
  logic [ADDR_W-1:0]      s2_prod_r;
  logic [COORD_W-1:0]     s2_px_r;
  logic                   s2_on_r;
  logic                   s2_set_r;
  logic [COLOR_W-1:0]     s2_ink_r;
  logic                   s2_transp_r;
  logic                   s2_last_r;
  logic                   s1_on;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [COLOR_W-1:0]     out_color_r;
  logic                   out_we_r;
  logic                   out_last_r;

  assign adv = !out_valid_r || !out_stall;

  gpb_cmd_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_char_code   (in_char_code),
    .in_ink_color   (in_ink_color),
    .in_transparent (in_transparent),
    .adv            (adv),
    .slot           (slot)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bg_r <= cfg_data;
    end
  end

  // glyph fetch and pixel coordinates
  assign row_bits = glyph_row(slot.gidx, slot.row);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r     <= {slot.x[COORD_W-1], slot.x} + PIX_COORD_W'(slot.col);
      s1_py_r     <= {slot.y[COORD_W-1], slot.y} + PIX_COORD_W'(slot.row);
      s1_set_r    <= row_bits[~slot.col];
      s1_ink_r    <= slot.ink;
      s1_transp_r <= slot.transp;
      s1_last_r   <= (slot.row == LAST_ROW) && (slot.col == LAST_COL);
    end
  end

  // bounds check and row offset
  assign s1_on = !s1_px_r[PIX_COORD_W-1] && (s1_px_r[COORD_W-1:0] < W_LIM) &&
                 !s1_py_r[PIX_COORD_W-1] && (s1_py_r[COORD_W-1:0] < H_LIM);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r   <= ADDR_W'(ADDR_W'(s1_py_r[COORD_W-1:0]) * W_MUL);
      s2_px_r     <= s1_px_r[COORD_W-1:0];
      s2_on_r     <= s1_on;
      s2_set_r    <= s1_set_r;
      s2_ink_r    <= s1_ink_r;
      s2_transp_r <= s1_transp_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // address add and color select
  always_ff @(posedge clk) begin
    if (adv) begin
      out_addr_r  <= s2_on_r ? ADDR_W'(s2_prod_r + ADDR_W'(s2_px_r)) : '0;
      out_we_r    <= s2_on_r && (s2_set_r || !s2_transp_r);
      out_last_r  <= s2_last_r;
      if (!s2_on_r) begin
        out_color_r <= '0;
      end else if (s2_set_r) begin
        out_color_r <= s2_ink_r;
      end else if (!s2_transp_r) begin
        out_color_r <= bg_r;
      end else begin
        out_color_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= slot.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_addr   = out_addr_r;
  assign out_pixel_color  = out_color_r;
  assign out_write_enable = out_we_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_color_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_pixel_color == '0))
    else $error("pixel color set on a beat with write enable low");

  a_busy_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (slot.valid && !$past(slot.valid)) |-> $past(in_valid && !in_stall))
    else $error("sequencer started without an accepted command");

  a_pipe_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && s2_valid_r) |=> s2_valid_r)
    else $error("pixel dropped from pipeline under stall");
`endif

endmodule

@@ verif/glyph_pixel_blitter_unit_test.sv @@
module glyph_pixel_blitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gpb_pkg::*;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;
  localparam int CELL_ROWS = 7;
  localparam int CELL_COLS = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_MAX = 10;

  typedef enum logic [0:0] {CHK_MODEL, CHK_BLANK} check_kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CODE_W-1:0]         code;
    logic [COLOR_W-1:0]        ink;
    logic                      transp;
  } draw_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               we;
    logic               last;
  } pixel_beat_t;

  typedef struct packed {
    check_kind_t        kind;
    logic               set_bg;
    logic [COLOR_W-1:0] bg;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] ink;
    logic               transp;
  } directed_row_t;

  localparam int N_DIRECTED = 23;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{CHK_MODEL, 1'b0, 8'h00, 11'd0,   11'd0,   " ",   8'hFF, 1'b0},
    '{CHK_MODEL, 1'b0, 8'h00, 11'd0,   11'd0,   "0",   8'h11, 1'b1},
    '{CHK_BLANK, 1'b0, 8'h00, 11'h400, 11'h400, 8'h00, 8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'h00, 11'h3FF, 11'h3FF, 8'hFF, 8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'h00, 11'd320, 11'd0,   "8",   8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'h00, 11'h7F8, 11'd0,   "8",   8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'h00, 11'd0,   11'd200, "8",   8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'h00, 11'd0,   11'h7F9, "8",   8'hFF, 1'b0},
    '{CHK_MODEL, 1'b1, 8'hFF, 11'd312, 11'd193, "A",   8'h00, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hFF, 11'd313, 11'd194, "W",   8'h80, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hFF, 11'h7FD, 11'h7FE, "M",   8'h3C, 1'b1},
    '{CHK_MODEL, 1'b0, 8'hFF, 11'd100, 11'd100, 8'h80, 8'hC3, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hFF, 11'd200, 11'd150, 8'hFF, 8'h01, 1'b1},
    '{CHK_MODEL, 1'b0, 8'hFF, 11'd50,  11'd50,  ":",   8'hFE, 1'b1},
    '{CHK_MODEL, 1'b1, 8'h00, 11'd7,   11'd9,   "Z",   8'hFF, 1'b0},
    '{CHK_MODEL, 1'b0, 8'h00, 11'd0,   11'd192, "y",   8'hAA, 1'b0},
    '{CHK_MODEL, 1'b0, 8'h00, 11'd316, 11'd0,   "g",   8'h55, 1'b1},
    '{CHK_MODEL, 1'b1, 8'hA5, 11'd160, 11'd100, "e",   8'h5A, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hA5, 11'd1,   11'd1,   "k",   8'h0F, 1'b1},
    '{CHK_BLANK, 1'b0, 8'hA5, 11'h3FF, 11'd0,   "x",   8'hFF, 1'b0},
    '{CHK_BLANK, 1'b0, 8'hA5, 11'd0,   11'h3FF, " ",   8'hFF, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hA5, 11'd319, 11'd199, "9",   8'hF0, 1'b0},
    '{CHK_MODEL, 1'b0, 8'hA5, 11'h7FF, 11'h7FF, "@",   8'h77, 1'b0}
  };

  localparam logic [55:0] FONT [47] = '{
    56'h70888888888870, 56'h20602020202070, 56'h708808102040F8, 56'h70880830088870,
    56'h10305090F81010, 56'hF880F008088870, 56'h304080F0888870, 56'hF8081020404040,
    56'h70888870888870, 56'h70888878081060, 56'h00200000002000, 56'h20508888F88888,
    56'hF88080F08080F8, 56'hF88080F0808080, 56'h708880B8888870, 56'h70202020202070,
    56'h808080808080F8, 56'h88D8A8A8888888, 56'h8888C8A8988888, 56'h70888888888870,
    56'hF08888F0808080, 56'hF08888F0908888, 56'h70888070088870, 56'h88888888888870,
    56'h88888888505020, 56'h888888A8A8D888, 56'h88885020202020, 56'h00007008788878,
    56'h00007080808870, 56'h00007088F88070, 56'h20006020202070, 56'h808090A0E09088,
    56'h60202020202070, 56'h0000B0C8888888, 56'h00007088888870, 56'h00006870404040,
    56'h000070807008F0, 56'h20207020202018, 56'h00008888885020, 56'h00008850205088,
    56'h00008888780870, 56'h00000000000000, 56'h70888080808870, 56'hF08888888888F0,
    56'h8898A8C0A89888, 56'hF80810204080F8, 56'hF8F8F8F8F8F8F8
  };

  localparam logic [COLOR_W-1:0] PHASE_BG [N_PHASES] = '{
    8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_x_pos = '0;
  logic signed [COORD_W-1:0] in_y_pos = '0;
  logic [CODE_W-1:0]         in_char_code = '0;
  logic [COLOR_W-1:0]        in_ink_color = '0;
  logic                      in_transparent = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ADDR_W-1:0]         out_pixel_addr;
  logic [COLOR_W-1:0]        out_pixel_color;
  logic                      out_write_enable;
  logic                      out_last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [COLOR_W-1:0]        cfg_data = '0;

  pixel_beat_t        pending_pixels [$];
  logic [COLOR_W-1:0] background = '0;
  string              glyph_chars = "0123456789:ACDEFGIKLMNOPRSUVWYZacdeiklnorstvxy ";
  bit                 gap_free = 1'b0;
  bit                 rx_busy = 1'b1;
  int                 holdoff_asked = 0;
  int                 holdoff_taken = 0;
  int                 stall_left = 0;
  int                 cycle_count = 0;
  int                 failures = 0;
  int                 beats_checked = 0;
  int                 cmds_sent = 0;
  int                 bg_writes = 0;

  glyph_pixel_blitter_unit #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_char_code    (in_char_code),
    .in_ink_color    (in_ink_color),
    .in_transparent  (in_transparent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_addr  (out_pixel_addr),
    .out_pixel_color (out_pixel_color),
    .out_write_enable(out_write_enable),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_glyph_cell(input draw_cmd_t cmd);
    int          slot;
    int          px;
    int          py;
    logic [7:0]  row_bits;
    pixel_beat_t beat;
    if (cmd.code >= "0" && cmd.code <= "9") begin
      slot = int'(cmd.code) - int'("0");
    end else begin
      case (cmd.code)
        ":": slot = 10;  "A": slot = 11;  "C": slot = 42;  "D": slot = 43;
        "E": slot = 12;  "F": slot = 13;  "G": slot = 14;  "I": slot = 15;
        "K": slot = 44;  "L": slot = 16;  "M": slot = 17;  "N": slot = 18;
        "O": slot = 19;  "P": slot = 20;  "R": slot = 21;  "S": slot = 22;
        "U": slot = 23;  "V": slot = 24;  "W": slot = 25;  "Y": slot = 26;
        "Z": slot = 45;  "a": slot = 27;  "c": slot = 28;  "e": slot = 29;
        "i": slot = 30;  "k": slot = 31;  "l": slot = 32;  "n": slot = 33;
        "o": slot = 34;  "r": slot = 35;  "s": slot = 36;  "t": slot = 37;
        "v": slot = 38;  "x": slot = 39;  "y": slot = 40;  " ": slot = 41;
        default: slot = 46;
      endcase
    end
    for (int r = 0; r < CELL_ROWS; r++) begin
      row_bits = FONT[slot][55 - 8 * r -: 8];
      for (int j = 0; j < CELL_COLS; j++) begin
        px = int'(cmd.x) + j;
        py = int'(cmd.y) + r;
        beat = '0;
        if (px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H) begin
          beat.addr = ADDR_W'(py * SCREEN_W + px);
          if (row_bits[7 - j]) begin
            beat.color = cmd.ink;
            beat.we = 1'b1;
          end else if (!cmd.transp) begin
            beat.color = background;
            beat.we = 1'b1;
          end
        end
        beat.last = (r == CELL_ROWS - 1) && (j == CELL_COLS - 1);
        pending_pixels.push_back(beat);
      end
    end
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_background(input logic [COLOR_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    background = value;
    bg_writes++;
  endtask

  task automatic send_cmd(input draw_cmd_t cmd, input check_kind_t kind);
    int          gap;
    int unsigned roll;
    pixel_beat_t beat;
    roll = $urandom_range(0, 99);
    if (gap_free || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_pos <= cmd.x;
    in_y_pos <= cmd.y;
    in_char_code <= cmd.code;
    in_ink_color <= cmd.ink;
    in_transparent <= cmd.transp;
    // hold the command until accepted
    do @(posedge clk); while (in_stall);
    if (kind == CHK_BLANK) begin
      for (int n = 0; n < CELL_ROWS * CELL_COLS; n++) begin
        beat = '0;
        beat.last = (n == CELL_ROWS * CELL_COLS - 1);
        pending_pixels.push_back(beat);
      end
    end else begin
      predict_glyph_cell(cmd);
    end
    cmds_sent++;
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_busy = !rx_busy;
    if (holdoff_taken != holdoff_asked) begin
      holdoff_taken = holdoff_asked;
      stall_left = HOLDOFF_CYCLES;
    end else if (stall_left == 0 && rx_busy && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 20);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_addr, out_pixel_color, out_write_enable, out_last};
      beats_checked++;
      if (pending_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("Unexpected pixel beat: addr %h color %h we %b last %b",
                   got.addr, got.color, got.we, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.addr !== want.addr || got.color !== want.color ||
            got.we !== want.we || got.last !== want.last) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display({"Mismatch at beat %0d: addr exp %h got %h, color exp %h got %h, ",
                      "we exp %b got %b, last exp %b got %b"},
                     beats_checked, want.addr, got.addr, want.color, got.color,
                     want.we, got.we, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d pixel beats outstanding",
               cycle_count, pending_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    draw_cmd_t     cmd;
    directed_row_t row;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.set_bg) write_background(row.bg);
      cmd = '{row.x, row.y, row.code, row.ink, row.transp};
      send_cmd(cmd, row.kind);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      write_background((phase >= 6) ? COLOR_W'($urandom) : PHASE_BG[phase]);
      gap_free = (phase == 2) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 3 && k == 10) holdoff_asked++;
        if (phase == 5 && k == 30) wait_idle();
        if ($urandom_range(0, 3) != 0) begin
          cmd.x = COORD_W'(int'($urandom_range(0, 340)) - 12);
          cmd.y = COORD_W'(int'($urandom_range(0, 217)) - 10);
        end else begin
          cmd.x = COORD_W'($urandom);
          cmd.y = COORD_W'($urandom);
        end
        if ($urandom_range(0, 9) < 7)
          cmd.code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
        else
          cmd.code = CODE_W'($urandom);
        cmd.ink = COLOR_W'($urandom);
        cmd.transp = 1'($urandom);
        send_cmd(cmd, CHK_MODEL);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      failures++;
      $display("%0d pixel beats never arrived", pending_pixels.size());
    end

    $display("Drew %0d glyph cells (%0d from the directed table), checked %0d pixel beats",
             cmds_sent, N_DIRECTED, beats_checked);
    $display("Used %0d background colors, a long output hold-off and idle drains; %0d failures",
             bg_writes, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
